// ===== hw/rtl/qeb_pkg.sv =====
// ----------------------------------------------------------------------------
// qeb_pkg: shared types and constants for the quadrature encoder block
// Payload structs, item kind codes, event codes, register indexes and the
// x4 quadrature step table.
// ----------------------------------------------------------------------------
`default_nettype none

package qeb_pkg;

   localparam int ENCODER_COUNT_DEFAULT = 2;
   localparam int LINE_W                = 2;
   localparam int STAMP_W               = 32;
   localparam int COUNT_W               = 32;
   localparam int HOLD_W                = 16;
   localparam int CSR_INDEX_W           = 4;
   localparam int CSR_DATA_W            = 16;

   localparam logic [HOLD_W-1:0] LONG_PRESS_RESET    = 16'd500;
   localparam logic [LINE_W-1:0] SWITCH_ENABLE_RESET = 2'b11;
   localparam logic [1:0]        PHASE_IDLE          = 2'b11;

   // item kinds
   localparam logic [2:0] KIND_SAMPLE    = 3'd0;
   localparam logic [2:0] KIND_POLL      = 3'd1;
   localparam logic [2:0] KIND_TAKE      = 3'd2;
   localparam logic [2:0] KIND_SET_POS   = 3'd3;
   localparam logic [2:0] KIND_RESET_POS = 3'd4;

   // event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_CW       = 3'd1;
   localparam logic [2:0] EV_CCW      = 3'd2;
   localparam logic [2:0] EV_PRESSED  = 3'd3;
   localparam logic [2:0] EV_RELEASED = 3'd4;
   localparam logic [2:0] EV_LONG     = 3'd5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_ENABLE = 4'd1;

   typedef struct packed {
      logic [2:0]                kind;
      logic                      encoder_sel;
      logic [LINE_W-1:0]         line_a;
      logic [LINE_W-1:0]         line_b;
      logic [LINE_W-1:0]         line_sw;
      logic [STAMP_W-1:0]        now_ms;
      logic signed [COUNT_W-1:0] new_position;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]                event_res;
      logic signed [COUNT_W-1:0] delta;
      logic signed [COUNT_W-1:0] position;
      logic                      switch_down;
   } rsp_payload_type;

   // old phase x new phase, phase = {A, B}
   function automatic logic signed [1:0] phase_step(input logic [1:0] old_ph,
                                                    input logic [1:0] new_ph);
      logic signed [1:0] step;
      step = 2'sd0;
      unique case ({old_ph, new_ph})
         4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: step = -2'sd1;
         4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: step = 2'sd1;
         default:                                step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/quadrature_encoder_with_button.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button: rotary encoders with push switches
// x4 quadrature decoding, wrapping position and delta counters, switch
// press / release / long-press tracking and a prioritised event poll.
// ----------------------------------------------------------------------------
// One request transfer is taken every cycle while the response side is not
// stalled. A request lands in an input register; when the work stage advances,
// the per-encoder logic (quadrature table, two 32-bit adds, one 32-bit
// hold-time compare) updates the state and loads the response register, which
// drives rsp_valid; throughput is one item per clock while rsp_ready stays
// high. The response register
// decouples the sides: a stalled response holds the item in the input
// register, and req_ready drops only when both registers are full and
// rsp_ready is low. Sample items update every encoder; poll, take, set and
// reset items act on encoder_sel only. Configuration writes are always ready
// and should be issued only while no item is in flight.
`default_nettype none

module quadrature_encoder_with_button
   import qeb_pkg::*;
#(
   parameter int ENCODER_COUNT = ENCODER_COUNT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_payload_type        req_payload,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_payload_type             rsp_payload,
   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // input and output stage
   logic            req_valid_ff;
   req_payload_type req_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            advance;

   // configuration
   logic [HOLD_W-1:0] long_press_ff;
   logic [LINE_W-1:0] switch_enable_ff;

   // per-encoder state
   logic [COUNT_W-1:0]       position_ff [ENCODER_COUNT];
   logic [COUNT_W-1:0]       position_in [ENCODER_COUNT];
   logic [COUNT_W-1:0]       delta_ff    [ENCODER_COUNT];
   logic [COUNT_W-1:0]       delta_in    [ENCODER_COUNT];
   logic [1:0]               phase_ff    [ENCODER_COUNT];
   logic [1:0]               phase_in    [ENCODER_COUNT];
   logic [STAMP_W-1:0]       stamp_ff    [ENCODER_COUNT];
   logic [STAMP_W-1:0]       stamp_in    [ENCODER_COUNT];
   logic [ENCODER_COUNT-1:0] pressed_ff,  pressed_in;
   logic [ENCODER_COUNT-1:0] long_ff,     long_in;
   logic [ENCODER_COUNT-1:0] reported_ff, reported_in;

   // encoders beyond the two wired lines read 0
   logic [ENCODER_COUNT-1:0] a_ext, b_ext, sw_ext, en_ext;

   assign a_ext  = ENCODER_COUNT'(req_data_ff.line_a);
   assign b_ext  = ENCODER_COUNT'(req_data_ff.line_b);
   assign sw_ext = ENCODER_COUNT'(req_data_ff.line_sw);
   assign en_ext = ENCODER_COUNT'(switch_enable_ff);

   // the work stage moves when the response register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      logic              sel_ok;
      logic              hit;
      logic              down;
      logic [1:0]        phase;
      logic signed [1:0] dir;
      logic [STAMP_W-1:0] held;

      sel_ok = int'(req_data_ff.encoder_sel) < ENCODER_COUNT;
      hit    = 1'b0;
      down   = 1'b0;
      phase  = PHASE_IDLE;
      dir    = 2'sd0;
      held   = '0;
      rsp_data_in = '0;
      pressed_in  = pressed_ff;
      long_in     = long_ff;
      reported_in = reported_ff;

      for (int i = 0; i < ENCODER_COUNT; i++) begin
         position_in[i] = position_ff[i];
         delta_in[i]    = delta_ff[i];
         phase_in[i]    = phase_ff[i];
         stamp_in[i]    = stamp_ff[i];
         hit = sel_ok && (int'(req_data_ff.encoder_sel) == i);

         if (req_data_ff.kind == KIND_SAMPLE) begin
            // quadrature step; a double change gives 0 but the phase is kept
            phase = {a_ext[i], b_ext[i]};
            dir   = phase_step(phase_ff[i], phase);
            position_in[i] = position_ff[i] + COUNT_W'(dir);
            delta_in[i]    = delta_ff[i] + COUNT_W'(dir);
            phase_in[i]    = phase;

            down = !sw_ext[i];
            held = req_data_ff.now_ms - stamp_ff[i];
            if (en_ext[i]) begin
               priority if (down && !pressed_ff[i]) begin
                  pressed_in[i] = 1'b1;
                  stamp_in[i]   = req_data_ff.now_ms;
                  long_in[i]    = 1'b0;
               end else if (!down && pressed_ff[i]) begin
                  pressed_in[i] = 1'b0;
               end else if (pressed_ff[i] && !long_ff[i]) begin
                  if (held > STAMP_W'(long_press_ff)) begin
                     long_in[i] = 1'b1;
                  end
               end else begin
                  // idle, or held with the flag already up: switch state stays
               end
            end
         end else if (hit) begin
            unique case (req_data_ff.kind)
               KIND_POLL: begin
                  // movement first, then press, release, long press
                  priority if (delta_ff[i] != '0) begin
                     delta_in[i] = '0;
                     rsp_data_in.event_res = delta_ff[i][COUNT_W-1] ? EV_CCW : EV_CW;
                  end else if (pressed_ff[i] && !reported_ff[i]) begin
                     reported_in[i] = 1'b1;
                     rsp_data_in.event_res = EV_PRESSED;
                  end else if (!pressed_ff[i] && reported_ff[i]) begin
                     reported_in[i] = 1'b0;
                     rsp_data_in.event_res = EV_RELEASED;
                  end else if (long_ff[i]) begin
                     long_in[i] = 1'b0;
                     rsp_data_in.event_res = EV_LONG;
                  end else begin
                     rsp_data_in.event_res = EV_NONE;
                  end
               end
               KIND_TAKE: begin
                  rsp_data_in.delta = delta_ff[i];
                  delta_in[i] = '0;
               end
               KIND_SET_POS: begin
                  position_in[i] = req_data_ff.new_position;
               end
               KIND_RESET_POS: begin
                  position_in[i] = '0;
                  delta_in[i]    = '0;
               end
               default: begin
               end
            endcase
         end

         if (hit) begin
            rsp_data_in.position    = position_in[i];
            rsp_data_in.switch_down = pressed_in[i];
         end
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         long_press_ff    <= LONG_PRESS_RESET;
         switch_enable_ff <= SWITCH_ENABLE_RESET;
         pressed_ff       <= '0;
         long_ff          <= '0;
         reported_ff      <= '0;
         for (int i = 0; i < ENCODER_COUNT; i++) begin
            position_ff[i] <= '0;
            delta_ff[i]    <= '0;
            phase_ff[i]    <= PHASE_IDLE;
            stamp_ff[i]    <= '0;
         end
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            pressed_ff  <= pressed_in;
            long_ff     <= long_in;
            reported_ff <= reported_in;
            for (int i = 0; i < ENCODER_COUNT; i++) begin
               position_ff[i] <= position_in[i];
               delta_ff[i]    <= delta_in[i];
               phase_ff[i]    <= phase_in[i];
               stamp_ff[i]    <= stamp_in[i];
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LONG_PRESS) begin
               long_press_ff <= csr_data;
            end else if (csr_index == CSR_SWITCH_ENABLE) begin
               switch_enable_ff <= csr_data[LINE_W-1:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/qeb_checker.sv =====
// ----------------------------------------------------------------------------
// qeb_checker: port-level checks for the quadrature encoder block
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module qeb_checker
   import qeb_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire rsp_payload_type        rsp_payload
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped or changed while stalled");

   // every request transfer yields a valid response through the input and response registers
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("request transfer without response");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // only a poll reports an event, only a take reports a delta
   a_event_delta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.delta != '0)) |-> (rsp_payload.event_res == EV_NONE))
      else $error("event and delta in one response");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.event_res <= EV_LONG))
      else $error("event code out of range");

endmodule

bind quadrature_encoder_with_button qeb_checker u_qeb_checker (.*);

`default_nettype wire

// ===== verif/quadrature_encoder_with_button_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button_checker: response predictor and comparator
// Watches the request, response and register write channels of the encoder
// block, keeps a private copy of its state and checks every response transfer.
// ----------------------------------------------------------------------------

module quadrature_encoder_with_button_checker
   import qeb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire req_payload_type        req_payload,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rsp_payload_type        rsp_payload,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          mismatch_count,
   output int                          results_due,
   output int                          results_checked
);

   localparam int ENCODERS = ENCODER_COUNT_DEFAULT;

   // x4 step, indexed [old {A,B}][new {A,B}]
   localparam int TURN_STEP [4][4] = '{
      '{ 0, -1,  1,  0},
      '{ 1,  0,  0, -1},
      '{-1,  0,  0,  1},
      '{ 0,  1, -1,  0}
   };

   logic [HOLD_W-1:0]  hold_limit;
   logic [LINE_W-1:0]  sw_mask;

   logic [COUNT_W-1:0] pos_q     [ENCODERS];
   logic [COUNT_W-1:0] delta_q   [ENCODERS];
   logic [1:0]         last_ph   [ENCODERS];
   logic               pressed_q [ENCODERS];
   logic [STAMP_W-1:0] stamp_q   [ENCODERS];
   logic               long_q    [ENCODERS];
   logic               shown_q   [ENCODERS];

   rsp_payload_type    predicted_rsp [$];

   task automatic decode_item(input req_payload_type it, output rsp_payload_type want);
      logic [1:0]         ph;
      logic [STAMP_W-1:0] held;
      int                 sel;
      want = '0;
      sel  = it.encoder_sel;
      if (it.kind == KIND_SAMPLE) begin
         for (int e = 0; e < ENCODERS; e++) begin
            ph         = {it.line_a[e], it.line_b[e]};
            pos_q[e]   = pos_q[e] + TURN_STEP[last_ph[e]][ph];
            delta_q[e] = delta_q[e] + TURN_STEP[last_ph[e]][ph];
            last_ph[e] = ph;
            if (sw_mask[e]) begin
               if (!it.line_sw[e] && !pressed_q[e]) begin
                  pressed_q[e] = 1'b1;
                  stamp_q[e]   = it.now_ms;
                  long_q[e]    = 1'b0;
               end else if (it.line_sw[e] && pressed_q[e]) begin
                  pressed_q[e] = 1'b0;
               end else if (pressed_q[e] && !long_q[e]) begin
                  held = it.now_ms - stamp_q[e];
                  if (held > hold_limit) long_q[e] = 1'b1;
               end
            end
         end
      end
      case (it.kind)
         KIND_POLL: begin
            if (delta_q[sel] != '0) begin
               want.event_res = delta_q[sel][COUNT_W-1] ? EV_CCW : EV_CW;
               delta_q[sel]   = '0;
            end else if (pressed_q[sel] && !shown_q[sel]) begin
               want.event_res = EV_PRESSED;
               shown_q[sel]   = 1'b1;
            end else if (!pressed_q[sel] && shown_q[sel]) begin
               want.event_res = EV_RELEASED;
               shown_q[sel]   = 1'b0;
            end else if (long_q[sel]) begin
               want.event_res = EV_LONG;
               long_q[sel]    = 1'b0;
            end
         end
         KIND_TAKE: begin
            want.delta   = delta_q[sel];
            delta_q[sel] = '0;
         end
         KIND_SET_POS: begin
            pos_q[sel] = it.new_position;
         end
         KIND_RESET_POS: begin
            pos_q[sel]   = '0;
            delta_q[sel] = '0;
         end
         default: ;
      endcase
      want.position    = pos_q[sel];
      want.switch_down = pressed_q[sel];
   endtask

   task automatic compare_field(input string name, input logic signed [COUNT_W-1:0] want,
                                input logic signed [COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         hold_limit = LONG_PRESS_RESET;
         sw_mask    = SWITCH_ENABLE_RESET;
         for (int e = 0; e < ENCODERS; e++) begin
            pos_q[e]     = '0;
            delta_q[e]   = '0;
            last_ph[e]   = PHASE_IDLE;
            pressed_q[e] = 1'b0;
            stamp_q[e]   = '0;
            long_q[e]    = 1'b0;
            shown_q[e]   = 1'b0;
         end
         predicted_rsp.delete();
         results_due <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LONG_PRESS:    hold_limit = csr_data;
               CSR_SWITCH_ENABLE: sw_mask    = csr_data[LINE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decode_item(req_payload, want);
            predicted_rsp.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t ns: unexpected response transfer, expected none, actual event %0d",
                        $time, rsp_payload.event_res);
               mismatch_count++;
            end else begin
               want = predicted_rsp.pop_front();
               compare_field("event_res", COUNT_W'(want.event_res),
                             COUNT_W'(rsp_payload.event_res));
               compare_field("delta", want.delta, rsp_payload.delta);
               compare_field("position", want.position, rsp_payload.position);
               compare_field("switch_down", COUNT_W'(want.switch_down),
                             COUNT_W'(rsp_payload.switch_down));
               results_checked++;
            end
         end
         results_due <= predicted_rsp.size();
      end
   end

endmodule

// ===== verif/quadrature_encoder_with_button_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button_tb: top-level testbench for the encoder block
// Drives a directed opening and then quadrature-shaped random traffic through
// several long-press / switch-mask settings, with idling on both sides; a
// separate checker predicts and compares every response transfer.
// ----------------------------------------------------------------------------

module quadrature_encoder_with_button_tb
   import qeb_pkg::*;
;

   localparam int ENCODERS = ENCODER_COUNT_DEFAULT;

   // kinds the block does not define; they must leave state alone
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   // register indexes with no register behind them
   localparam int CSR_UNUSED_FIRST = int'(CSR_SWITCH_ENABLE) + 1;
   localparam int CSR_UNUSED_LAST  = (1 << CSR_INDEX_W) - 1;

   // next {A,B} phase for a clockwise (+1) and an anticlockwise (-1) detent step
   localparam logic [1:0] CW_NEXT  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] CCW_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   // Random phases: limit, switch mask, sender gap %, receiver stall %, items.
   // Sender-light / receiver-heavy idling first, then swapped, then none.
   localparam int PHASES = 5;
   localparam logic [HOLD_W-1:0] HOLD_SET  [PHASES] = '{16'd0, 16'd65535, 16'd7, 16'd20, 16'd40};
   localparam logic [LINE_W-1:0] MASK_SET  [PHASES] = '{2'b11, 2'b10, 2'b01, 2'b00, 2'b11};
   localparam int                GAP_SET   [PHASES] = '{31, 31, 78, 0, 0};
   localparam int                STALL_SET [PHASES] = '{78, 78, 31, 0, 0};
   localparam int                ITEMS_SET [PHASES] = '{350, 300, 300, 150, 250};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatch_count;
   int results_due;
   int results_checked;

   // idling odds, changed per phase
   int gap_pct   = 0;
   int stall_pct = 0;

   // line levels last sent, so random rotation carries on from there
   logic [LINE_W-1:0]  line_a_now  = '1;
   logic [LINE_W-1:0]  line_b_now  = '1;
   logic [LINE_W-1:0]  line_sw_now = '1;
   logic [STAMP_W-1:0] ms_now      = '0;
   logic               turn_cw [ENCODERS] = '{default: 1'b1};

   int items_sent   = 0;
   int samples_sent = 0;
   int polls_sent   = 0;
   int csr_writes   = 0;

   quadrature_encoder_with_button dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   quadrature_encoder_with_button_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_due     (results_due),
      .results_checked (results_checked)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: stalls at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // One request transfer. An optional gap drops valid first; otherwise valid
   // stays high straight on from the previous transfer, so it is never
   // lowered and raised in the same step.
   task automatic send(input req_payload_type it);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < gap_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (it.kind == KIND_POLL) polls_sent++;
      if (it.kind == KIND_SAMPLE) begin
         samples_sent++;
         line_a_now  = it.line_a;
         line_b_now  = it.line_b;
         line_sw_now = it.line_sw;
         ms_now      = it.now_ms;
      end
   endtask

   task automatic send_fields(input logic [2:0] kind, input logic sel,
                              input logic [LINE_W-1:0] a, input logic [LINE_W-1:0] b,
                              input logic [LINE_W-1:0] sw, input logic [STAMP_W-1:0] stamp,
                              input logic [COUNT_W-1:0] pos);
      req_payload_type it;
      it.kind         = kind;
      it.encoder_sel  = sel;
      it.line_a       = a;
      it.line_b       = b;
      it.line_sw      = sw;
      it.now_ms       = stamp;
      it.new_position = pos;
      send(it);
   endtask

   // Hold the sender off until every predicted response has been transferred.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // Stray write to an unmapped index, then the two real registers; valid
   // stays high across the three transfers.
   task automatic load_settings(input logic [HOLD_W-1:0] hold, input logic [LINE_W-1:0] mask);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_W'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST));
      csr_data  <= CSR_DATA_W'($urandom());
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_data  <= hold;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // upper data bits are don't-care for the mask register
      csr_index <= CSR_SWITCH_ENABLE;
      csr_data  <= {(CSR_DATA_W - LINE_W)'($urandom()), mask};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      csr_writes += 3;
   endtask

   initial begin
      req_payload_type item;
      logic [95:0]     noise;
      logic [1:0]      ph;
      int              roll;

      repeat (7) @(posedge clock);
      reset     <= 1'b0;
      gap_pct   = GAP_SET[0];
      stall_pct = STALL_SET[0];

      // ---- directed opening, reset settings (limit 500, both switches) ----
      send_fields(KIND_POLL,   1'b0, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);  // nothing pending
      // encoder 0 two clockwise steps, encoder 1 one anticlockwise step
      send_fields(KIND_SAMPLE, 1'b0, 2'b10, 2'b11, 2'b11, 32'd5, 32'd0);
      send_fields(KIND_SAMPLE, 1'b1, 2'b10, 2'b00, 2'b11, 32'd10, 32'd0);
      // encoder 0 jumps both lines at once: not counted, phase still taken
      send_fields(KIND_SAMPLE, 1'b0, 2'b11, 2'b01, 2'b11, 32'd15, 32'd0);
      send_fields(KIND_POLL,   1'b0, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);  // clockwise
      send_fields(KIND_POLL,   1'b1, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);  // anticlockwise
      // position wraps from the top of the signed range
      send_fields(KIND_SET_POS, 1'b0, 2'b11, 2'b11, 2'b00, '1, 32'h7FFF_FFFF);
      send_fields(KIND_SAMPLE, 1'b0, 2'b10, 2'b01, 2'b11, 32'd20, 32'd0);
      send_fields(KIND_TAKE,   1'b0, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);
      // and from the bottom, on encoder 1
      send_fields(KIND_SET_POS, 1'b1, 2'b00, 2'b00, 2'b11, 32'd0, 32'h8000_0000);
      send_fields(KIND_SAMPLE, 1'b1, 2'b00, 2'b01, 2'b11, 32'd25, 32'd0);
      send_fields(KIND_TAKE,   1'b1, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);
      send_fields(KIND_RESET_POS, 1'b1, 2'b11, 2'b11, 2'b11, '1, '1);
      // both switches down, then held exactly to the limit and one past it
      send_fields(KIND_SAMPLE, 1'b0, 2'b00, 2'b01, 2'b00, 32'd1000, 32'd0);
      send_fields(KIND_POLL,   1'b0, 2'b00, 2'b00, 2'b00, 32'd0, 32'd0);  // pressed
      send_fields(KIND_SAMPLE, 1'b0, 2'b00, 2'b01, 2'b00, 32'd1500, 32'd0);
      send_fields(KIND_SAMPLE, 1'b0, 2'b00, 2'b01, 2'b00, 32'd1501, 32'd0);
      send_fields(KIND_POLL,   1'b0, 2'b00, 2'b00, 2'b00, 32'd0, 32'd0);  // long press
      // still held: the next sample re-arms the long-press flag
      send_fields(KIND_SAMPLE, 1'b0, 2'b00, 2'b01, 2'b00, 32'd1600, 32'd0);
      send_fields(KIND_POLL,   1'b1, 2'b00, 2'b00, 2'b00, 32'd0, 32'd0);  // pressed
      send_fields(KIND_POLL,   1'b1, 2'b00, 2'b00, 2'b00, 32'd0, 32'd0);  // long press
      // release at the top of the timestamp range; release beats the long flag
      send_fields(KIND_SAMPLE, 1'b1, 2'b00, 2'b01, 2'b11, 32'hFFFF_FFFF, 32'd0);
      send_fields(KIND_POLL,   1'b0, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);  // released
      send_fields(KIND_POLL,   1'b0, 2'b00, 2'b00, 2'b11, 32'd0, 32'd0);  // long press
      // undefined kinds report state and change nothing
      send_fields(KIND_UNUSED_LO, 1'b0, 2'b11, 2'b11, 2'b00, '1, '1);
      send_fields(KIND_UNUSED_HI, 1'b1, 2'b11, 2'b11, 2'b00, '1, '1);
      wait_for_results();

      // ---- random phases, registers changed only with nothing in flight ----
      for (int p = 0; p < PHASES; p++) begin
         gap_pct   = GAP_SET[p];
         stall_pct = STALL_SET[p];
         load_settings(HOLD_SET[p], MASK_SET[p]);
         for (int n = 0; n < ITEMS_SET[p]; n++) begin
            // once, mid-phase, let the pipeline run completely dry
            if (p == 0 && n == ITEMS_SET[0] / 2) wait_for_results();
            // start from all-random fields so unused bits toggle too
            noise = {$urandom(), $urandom(), $urandom()};
            item  = noise[$bits(req_payload_type)-1:0];
            roll  = $urandom_range(0, 99);
            if (roll < 55) begin
               // well-formed sample: each encoder mostly turns detent by
               // detent with a sticky direction, sometimes jumps illegally
               item.kind = KIND_SAMPLE;
               for (int e = 0; e < ENCODERS; e++) begin
                  ph = {line_a_now[e], line_b_now[e]};
                  if ($urandom_range(0, 99) < 10) turn_cw[e] = ~turn_cw[e];
                  roll = $urandom_range(0, 99);
                  if (roll < 55) ph = turn_cw[e] ? CW_NEXT[ph] : CCW_NEXT[ph];
                  else if (roll < 60) ph = ~ph;
                  item.line_a[e]  = ph[1];
                  item.line_b[e]  = ph[0];
                  item.line_sw[e] = ($urandom_range(0, 99) < 6) ? ~line_sw_now[e]
                                                                : line_sw_now[e];
               end
               // mostly short steps in time, a few long enough for any limit,
               // and the odd arbitrary stamp to exercise the wrapping difference
               roll = $urandom_range(0, 99);
               if (roll < 70)      ms_now += $urandom_range(0, 20);
               else if (roll < 90) ms_now += $urandom_range(21, 300);
               else if (roll < 97) ms_now += $urandom_range(400, 900);
               else if (roll < 99) ms_now += $urandom_range(60000, 80000);
               else                ms_now  = $urandom();
               item.now_ms = ms_now;
            end else if (roll < 70) begin
               item.kind = KIND_POLL;
            end else if (roll < 78) begin
               item.kind = KIND_TAKE;
            end else if (roll < 86) begin
               item.kind = KIND_SET_POS;
               case ($urandom_range(0, 4))
                  0:       item.new_position = 32'h7FFF_FFFF;
                  1:       item.new_position = 32'h8000_0000;
                  2:       item.new_position = 32'hFFFF_FFFF;
                  default: ;
               endcase
            end else if (roll < 90) begin
               item.kind = KIND_RESET_POS;
            end else if (roll < 93) begin
               item.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            end
            // anything left is pure noise, any kind and any line levels
            send(item);
         end
         wait_for_results();
      end

      // settle: anything arriving now is a surplus response
      repeat (20) @(posedge clock);

      $display("Run covered %0d request transfers (%0d samples, %0d polls), %0d register writes",
               items_sent, samples_sent, polls_sent, csr_writes);
      $display("over limits 0 to 65535 and every switch mask; %0d responses checked",
               results_checked);
      if (mismatch_count == 0) begin
         $display("quadrature_encoder_with_button_tb: PASS");
      end else begin
         $display("quadrature_encoder_with_button_tb: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this traffic.
   initial begin
      #(5_000_000);
      $display("Timeout with %0d responses outstanding", results_due);
      $display("quadrature_encoder_with_button_tb: FAIL");
      $finish;
   end

endmodule
